FILE: rtl/core/blowfish_block_cipher_core_defines.svh
// Assertion macros used by the checker of the Blowfish core.
`ifndef BLOWFISH_BLOCK_CIPHER_CORE_DEFINES_SVH
`define BLOWFISH_BLOCK_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BF_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BF_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

FILE: rtl/core/bf_pkg.sv
package bf_pkg;

    localparam int ROUNDS        = 16;
    localparam int SUBKEY_DEPTH  = ROUNDS + 2;
    localparam int SK_IDX_W      = $clog2(SUBKEY_DEPTH);
    localparam int RND_W         = $clog2(ROUNDS);
    localparam int WORD_W        = 32;
    localparam int SBOX_COUNT    = 4;
    localparam int SBOX_ENTRIES  = 256;
    localparam int SBOX_ADDR_W   = $clog2(SBOX_ENTRIES);
    localparam int BOX_W         = $clog2(SBOX_COUNT);

    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ENCRYPT   = 2'd0,
        OP_DECRYPT   = 2'd1,
        OP_WR_SUBKEY = 2'd2,
        OP_WR_SBOX   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                    operation;
        logic [31:0]            block_left;
        logic [31:0]            block_right;
        logic [1:0]             box_select;
        logic [7:0]             entry_index;
        logic [31:0]            entry_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0]            result_left;
        logic [31:0]            result_right;
    } out_item_t;

    typedef struct packed {
        logic                   en;
        logic [SK_IDX_W-1:0]    idx;
        word_t                  word;
    } sk_wr_t;

    typedef struct packed {
        word_t                  first_key;
        word_t                  round_key;
        word_t                  white_left;
        word_t                  white_right;
    } sk_rd_t;

    typedef struct packed {
        word_t                  r_new;
        word_t                  l_swap;
        word_t                  fin_left;
        word_t                  fin_right;
    } rnd_res_t;

endpackage

FILE: rtl/core/bf_sbox_ram.sv
module bf_sbox_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/bf_subkey_file.sv
module bf_subkey_file
    import bf_pkg::*;
(
    input  logic                clk,
    input  sk_wr_t              wr,
    input  logic                decrypt,
    input  logic [SK_IDX_W-1:0] rd_idx,
    output sk_rd_t              rd
);

    word_t sk_reg [SUBKEY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            sk_reg[wr.idx] <= wr.word;
        end
    end

    // Whitening and first-round keys sit at fixed places; only the round key is indexed.
    always_comb
    begin
        rd.round_key   = sk_reg[rd_idx];
        rd.first_key   = decrypt ? sk_reg[ROUNDS + 1] : sk_reg[0];
        rd.white_left  = decrypt ? sk_reg[0] : sk_reg[ROUNDS + 1];
        rd.white_right = decrypt ? sk_reg[1] : sk_reg[ROUNDS];
    end

endmodule

FILE: rtl/core/bf_round_unit.sv
module bf_round_unit
    import bf_pkg::*;
(
    input  logic [SBOX_COUNT-1:0][WORD_W-1:0] sbox_word,
    input  word_t                             l_cur,
    input  word_t                             r_cur,
    input  sk_rd_t                            keys,
    output rnd_res_t                          res
);

    word_t f_val;

    always_comb
    begin
        f_val        = ((sbox_word[0] + sbox_word[1]) ^ sbox_word[2]) + sbox_word[3];
        res.r_new    = r_cur ^ f_val;
        // The swapped half picks up the next round's subkey straight away.
        res.l_swap   = res.r_new ^ keys.round_key;
        res.fin_left  = l_cur ^ keys.white_left;
        res.fin_right = res.r_new ^ keys.white_right;
    end

endmodule

FILE: rtl/core/blowfish_block_cipher_core.sv
// Blowfish ECB engine: one 64-bit block per encrypt or decrypt transaction.
// It runs one Feistel round per cycle through the S-box memories, but the last round
// holds while a previous result is still waiting; a new block or table write is
// accepted only while idle, so blocks never overlap.
// Reset (rst_n, asynchronous, active low) clears the state and data registers; the
// subkey and S-box tables are undefined until software loads them.
module blowfish_block_cipher_core
    import bf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_item_t  req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp_item
);

    // The engine is either waiting for a transaction or running the rounds of one block.
    typedef enum logic {
        ST_IDLE,
        ST_ROUND
    } state_t;

    state_t              state_reg,   state_next;
    logic                decrypt_reg, decrypt_next;
    logic [RND_W-1:0]    round_reg,   round_next;
    logic [SK_IDX_W-1:0] kidx_reg,    kidx_next;
    word_t               l_reg,       l_next;
    word_t               r_reg,       r_next;
    logic                rsp_valid_reg, rsp_valid_next;
    out_item_t           rsp_item_reg,  rsp_item_next;

    logic     req_fire;
    logic     start;
    logic     is_decrypt_req;
    logic     last;
    logic     finish;
    logic     advance;
    logic     wr_sbox;
    logic     key_decrypt;
    sk_wr_t   sk_wr;
    sk_rd_t   sk_rd;
    rnd_res_t rnd;

    logic [SBOX_COUNT-1:0][WORD_W-1:0] sbox_word;

    // Writes and block starts are only taken when idle, so a table write never
    // overlaps a block's reads and no forwarding is needed.
    assign req_ready      = (state_reg == ST_IDLE);
    assign req_fire       = req_valid && req_ready;
    assign is_decrypt_req = (req_item.operation == OP_DECRYPT);
    assign start          = req_fire &&
                            ((req_item.operation == OP_ENCRYPT) || is_decrypt_req);
    assign wr_sbox        = req_fire && (req_item.operation == OP_WR_SBOX);

    // Subkey writes beyond the array are dropped.
    assign sk_wr.en   = req_fire && (req_item.operation == OP_WR_SUBKEY) &&
                        (req_item.entry_index < SUBKEY_DEPTH);
    assign sk_wr.idx  = req_item.entry_index[SK_IDX_W-1:0];
    assign sk_wr.word = req_item.entry_word;

    assign key_decrypt = (state_reg == ST_IDLE) ? is_decrypt_req : decrypt_reg;

    // The last round waits here if the previous result has not yet been taken;
    // holding the left half keeps the S-box read addresses, so the data stays valid.
    assign last    = (state_reg == ST_ROUND) && (round_reg == RND_LAST);
    assign finish  = last && (!rsp_valid_reg || rsp_ready);
    assign advance = (state_reg == ST_ROUND) && !last;

    bf_subkey_file u_subkeys (
        .clk     (clk),
        .wr      (sk_wr),
        .decrypt (key_decrypt),
        .rd_idx  (kidx_reg),
        .rd      (sk_rd)
    );

    bf_round_unit u_round (
        .sbox_word (sbox_word),
        .l_cur     (l_reg),
        .r_cur     (r_reg),
        .keys      (sk_rd),
        .res       (rnd)
    );

    // One bank per S-box. Each is addressed by its byte of the next left half, so
    // the looked-up words arrive in the same cycle as the half they belong to.
    for (genvar b = 0; b < SBOX_COUNT; b++)
    begin : g_sbox
        bf_sbox_ram #(
            .DEPTH (SBOX_ENTRIES),
            .WIDTH (WORD_W)
        ) u_bank (
            .clk     (clk),
            .wr_en   (wr_sbox && (req_item.box_select == BOX_W'(b))),
            .wr_addr (req_item.entry_index),
            .wr_data (req_item.entry_word),
            .rd_addr (l_next[WORD_W-1-SBOX_ADDR_W*b -: SBOX_ADDR_W]),
            .rd_data (sbox_word[b])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        decrypt_next   = decrypt_reg;
        round_next     = round_reg;
        kidx_next      = kidx_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_item_next  = rsp_item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // The left half enters already mixed with the first subkey.
                    state_next   = ST_ROUND;
                    decrypt_next = is_decrypt_req;
                    round_next   = '0;
                    kidx_next    = is_decrypt_req ? SK_IDX_W'(ROUNDS) : SK_IDX_W'(1);
                    l_next       = req_item.block_left ^ sk_rd.first_key;
                    r_next       = req_item.block_right;
                end
            end
            ST_ROUND:
            begin
                if (advance)
                begin
                    round_next = round_reg + RND_W'(1);
                    kidx_next  = decrypt_reg ? (kidx_reg - SK_IDX_W'(1))
                                             : (kidx_reg + SK_IDX_W'(1));
                    l_next     = rnd.l_swap;
                    r_next     = l_reg;
                end
                else if (finish)
                begin
                    // The final round skips the swap and applies output whitening.
                    state_next                 = ST_IDLE;
                    rsp_valid_next             = 1'b1;
                    rsp_item_next.result_left  = rnd.fin_left;
                    rsp_item_next.result_right = rnd.fin_right;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            decrypt_reg   <= 1'b0;
            round_reg     <= '0;
            kidx_reg      <= '0;
            l_reg         <= '0;
            r_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            decrypt_reg   <= decrypt_next;
            round_reg     <= round_next;
            kidx_reg      <= kidx_next;
            l_reg         <= l_next;
            r_reg         <= r_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_item_reg  <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

FILE: rtl/core/bf_core_checker.sv
`include "blowfish_block_cipher_core_defines.svh"

module bf_core_checker
    import bf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input in_item_t  req_item,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_item_t rsp_item
);

    logic blk_fire;
    logic wr_fire;

    assign blk_fire = req_valid && req_ready &&
                      ((req_item.operation == OP_ENCRYPT) ||
                       (req_item.operation == OP_DECRYPT));
    assign wr_fire  = req_valid && req_ready &&
                      ((req_item.operation == OP_WR_SUBKEY) ||
                       (req_item.operation == OP_WR_SBOX));

    // A waiting result must not change or vanish.
    `BF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "result changed while stalled")

    // A block transaction keeps the engine busy in the following cycle.
    `BF_ASSERT_NEXT(a_blk_busy, clk, rst_n, blk_fire, !req_ready, "engine ready right after a block start")

    // A table write leaves the engine ready in the following cycle.
    `BF_ASSERT_NEXT(a_wr_single, clk, rst_n, wr_fire, req_ready, "engine busy after a table write")

    // A new result only appears as a block finishes, leaving the engine idle.
    `BF_ASSERT_IMPLY(a_rsp_idle, clk, rst_n, $rose(rsp_valid), req_ready, "result raised while engine busy")

endmodule

bind blowfish_block_cipher_core bf_core_checker u_bf_core_checker (.*);
